/* sv/touch_gesture_direction_classifier_defines.svh */
// Assertion macros for the checker file.
`ifndef TOUCH_GESTURE_DIRECTION_CLASSIFIER_DEFINES_SVH
`define TOUCH_GESTURE_DIRECTION_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TGDC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgdc check failed");

// Next-cycle implication, disabled during reset.
`define TGDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgdc check failed");

`endif

/* sv/tgdc_pkg.sv */
package tgdc_pkg;

  localparam int ACC_W = 24;
  localparam int DELTA_W = 16;
  localparam int THR_W = 16;
  localparam int T2_W = 2 * THR_W;
  localparam int SQ_W = 2 * ACC_W;
  localparam int SQ100_W = SQ_W + 7;

  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;

  localparam logic [3:0] FINGERS_THREE = 4'd3;
  localparam logic [3:0] FINGERS_FOUR = 4'd4;

  localparam int CODE_FOUR_BIT = 0;
  localparam int CODE_POS_BIT = 1;
  localparam int CODE_VERT_BIT = 2;
  localparam int CODE_PINCH_BIT = 3;
  localparam logic [3:0] CODE_POS_MASK = 4'b0010;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [3:0] code_t;

  typedef struct packed {
    acc_t sum_x;
    acc_t sum_y;
    logic over;
    logic horiz;
  } dist_res_t;

endpackage

/* sv/touch_gesture_direction_classifier.sv */
// Touch gesture direction classifier. Takes one gesture event per cycle on the
// req channel while req_stall is low and returns at most one 4-bit action code
// per event on the action channel, through the input and output registers. The
// sustained rate is one item per clock when the output is not stalled: the
// accumulator update (saturating add, two 24x24 squares, threshold compare and
// code decision) is combinational from the input register to the state and
// result registers. Writing cfg_wdata registers the squared threshold; write it
// only while idle. No memory is used and no clearing pass runs after reset.
module touch_gesture_direction_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tgdc_pkg::THR_W-1:0]    cfg_wdata,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    req_type,
  input  logic                          is_pinch,
  input  logic [3:0]                    finger_count,
  input  tgdc_pkg::delta_t              delta_x,
  input  tgdc_pkg::delta_t              delta_y,
  output logic                          action_valid,
  input  logic                          action_stall,
  output tgdc_pkg::code_t               action_code
);

  logic                         s1_valid;
  logic [1:0]                   s1_type;
  logic                         s1_pinch;
  logic [3:0]                   s1_fingers;
  tgdc_pkg::delta_t             s1_dx;
  tgdc_pkg::delta_t             s1_dy;
  tgdc_pkg::acc_t               sum_x;
  tgdc_pkg::acc_t               sum_y;
  tgdc_pkg::code_t              last_action;
  logic                         is_fresh;
  logic [tgdc_pkg::T2_W-1:0]    t2;

  logic                         s1_fire;
  logic                         req_take;
  logic                         do_emit;
  tgdc_pkg::dist_res_t          res;
  tgdc_pkg::code_t              code;
  logic                         emit;

  assign s1_fire   = s1_valid && (!action_valid || !action_stall);
  assign req_stall = s1_valid && !s1_fire;
  assign req_take  = req_valid && !req_stall;
  assign do_emit   = s1_fire && s1_type == tgdc_pkg::REQ_UPDATE && emit;

  tgdc_dist u_dist (
    .sum_x    (sum_x),
    .sum_y    (sum_y),
    .delta_x  (s1_dx),
    .delta_y  (s1_dy),
    .is_fresh (is_fresh),
    .t2       (t2),
    .res      (res)
  );

  tgdc_code u_code (
    .res          (res),
    .is_pinch     (s1_pinch),
    .finger_count (s1_fingers),
    .is_fresh     (is_fresh),
    .last_action  (last_action),
    .code         (code),
    .emit         (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      t2 <= '0;
    end else if (cfg_we) begin
      t2 <= tgdc_pkg::T2_W'(cfg_wdata) * tgdc_pkg::T2_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_type    <= req_type;
      s1_pinch   <= is_pinch;
      s1_fingers <= finger_count;
      s1_dx      <= delta_x;
      s1_dy      <= delta_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x       <= '0;
      sum_y       <= '0;
      last_action <= '0;
      is_fresh    <= 1'b1;
    end else if (s1_fire) begin
      case (s1_type)
        tgdc_pkg::REQ_BEGIN: begin
          sum_x    <= '0;
          sum_y    <= '0;
          is_fresh <= 1'b1;
        end
        tgdc_pkg::REQ_UPDATE: begin
          if (emit) begin
            sum_x       <= '0;
            sum_y       <= '0;
            last_action <= code;
            is_fresh    <= 1'b0;
          end else begin
            sum_x <= res.sum_x;
            sum_y <= res.sum_y;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      action_valid <= 1'b0;
    end else if (do_emit) begin
      action_valid <= 1'b1;
    end else if (!action_stall) begin
      action_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      action_code <= code;
    end
  end

endmodule

/* sv/tgdc_dist.sv */
module tgdc_dist (
  input  tgdc_pkg::acc_t               sum_x,
  input  tgdc_pkg::acc_t               sum_y,
  input  tgdc_pkg::delta_t             delta_x,
  input  tgdc_pkg::delta_t             delta_y,
  input  logic                         is_fresh,
  input  logic [tgdc_pkg::T2_W-1:0]    t2,
  output tgdc_pkg::dist_res_t          res
);

  logic signed [tgdc_pkg::ACC_W:0] wide_x;
  logic signed [tgdc_pkg::ACC_W:0] wide_y;
  tgdc_pkg::acc_t sx;
  tgdc_pkg::acc_t sy;
  logic [tgdc_pkg::ACC_W-1:0] ax;
  logic [tgdc_pkg::ACC_W-1:0] ay;
  logic [tgdc_pkg::SQ_W-1:0] d2;
  logic [tgdc_pkg::SQ100_W-1:0] d2_100;
  logic [tgdc_pkg::SQ100_W-1:0] d2_ext;

  assign wide_x = $signed({sum_x[tgdc_pkg::ACC_W-1], sum_x})
                + $signed((tgdc_pkg::ACC_W+1)'(delta_x));
  assign wide_y = $signed({sum_y[tgdc_pkg::ACC_W-1], sum_y})
                + $signed((tgdc_pkg::ACC_W+1)'(delta_y));

  always_comb begin
    if (wide_x[tgdc_pkg::ACC_W] != wide_x[tgdc_pkg::ACC_W-1]) begin
      sx = wide_x[tgdc_pkg::ACC_W] ? tgdc_pkg::ACC_MIN : tgdc_pkg::ACC_MAX;
    end else begin
      sx = wide_x[tgdc_pkg::ACC_W-1:0];
    end
    if (wide_y[tgdc_pkg::ACC_W] != wide_y[tgdc_pkg::ACC_W-1]) begin
      sy = wide_y[tgdc_pkg::ACC_W] ? tgdc_pkg::ACC_MIN : tgdc_pkg::ACC_MAX;
    end else begin
      sy = wide_y[tgdc_pkg::ACC_W-1:0];
    end
  end

  assign ax = sx[tgdc_pkg::ACC_W-1] ? (~sx + 1'b1) : sx;
  assign ay = sy[tgdc_pkg::ACC_W-1] ? (~sy + 1'b1) : sy;

  assign d2 = tgdc_pkg::SQ_W'(ax) * tgdc_pkg::SQ_W'(ax)
            + tgdc_pkg::SQ_W'(ay) * tgdc_pkg::SQ_W'(ay);

  assign d2_ext = tgdc_pkg::SQ100_W'(d2);
  assign d2_100 = (d2_ext << 6) + (d2_ext << 5) + (d2_ext << 2);

  assign res.sum_x = sx;
  assign res.sum_y = sy;
  assign res.horiz = ax > ay;
  assign res.over  = is_fresh ? (d2 > tgdc_pkg::SQ_W'(t2))
                              : (d2_100 > tgdc_pkg::SQ100_W'(t2));

endmodule

/* sv/tgdc_code.sv */
module tgdc_code (
  input  tgdc_pkg::dist_res_t res,
  input  logic                is_pinch,
  input  logic [3:0]          finger_count,
  input  logic                is_fresh,
  input  tgdc_pkg::code_t     last_action,
  output tgdc_pkg::code_t     code,
  output logic                emit
);

  logic fingers_ok;
  logic positive;

  always_comb begin
    fingers_ok = finger_count inside {tgdc_pkg::FINGERS_THREE, tgdc_pkg::FINGERS_FOUR};
    positive = res.horiz ? !res.sum_x[tgdc_pkg::ACC_W-1] : !res.sum_y[tgdc_pkg::ACC_W-1];
    code = '0;
    code[tgdc_pkg::CODE_PINCH_BIT] = is_pinch;
    code[tgdc_pkg::CODE_VERT_BIT]  = !res.horiz;
    code[tgdc_pkg::CODE_POS_BIT]   = positive;
    code[tgdc_pkg::CODE_FOUR_BIT]  = finger_count == tgdc_pkg::FINGERS_FOUR;
    emit = res.over && fingers_ok
        && (is_fresh || last_action == (code ^ tgdc_pkg::CODE_POS_MASK));
  end

endmodule

/* sv/tgdc_checker.sv */
`include "touch_gesture_direction_classifier_defines.svh"

module tgdc_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic [1:0]      req_type,
  input logic [3:0]      finger_count,
  input logic            action_valid,
  input logic            action_stall,
  input tgdc_pkg::code_t action_code
);

  `TGDC_ASSERT_NEXT(a_out_hold, clk, rst, action_valid && action_stall, action_valid && $stable(action_code))

  `TGDC_ASSERT_IMPLY(a_no_stall_when_empty, clk, rst, !action_valid, !req_stall)

  `TGDC_ASSERT_IMPLY(a_result_has_source, clk, rst, $rose(action_valid), $past(req_valid && !req_stall && req_type == tgdc_pkg::REQ_UPDATE && (finger_count == tgdc_pkg::FINGERS_THREE || finger_count == tgdc_pkg::FINGERS_FOUR), 2))

  `TGDC_ASSERT_IMPLY(a_fingers_match, clk, rst, $rose(action_valid), action_code[tgdc_pkg::CODE_FOUR_BIT] == $past(finger_count == tgdc_pkg::FINGERS_FOUR, 2))

endmodule

bind touch_gesture_direction_classifier tgdc_checker u_tgdc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .req_type     (req_type),
  .finger_count (finger_count),
  .action_valid (action_valid),
  .action_stall (action_stall),
  .action_code  (action_code)
);
